FILE: hw/rtl/mqcb_pkg.sv
// Shared constants, opcodes and control/status structs for the masked q-gram bitmap.
// No dependencies.
`timescale 1ns / 1ps

package mqcb_pkg;

   localparam int INDEX_BITS_DEF = 16;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_SCAN   = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic clear_start;
      logic clear_step;
      logic latch_req;
      logic bit_start;
      logic bit_mode;    // 0 extract, 1 deposit
      logic bit_step;
      logic rd_ins;
      logic wr_ins;
      logic rd_scan;
      logic scan_load;
      logic scan_next;
      logic take_bit;
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic bit_last;
      logic widx_ok;
      logic cur_zero;
      logic scan_end;
      logic out_free;
      logic out_last;
   } sts_type;

endpackage

FILE: hw/rtl/mqcb_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on nothing.
`timescale 1ns / 1ps

interface mqcb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [63:0] gram;
   logic [9:0]  word_index;
   modport source (output valid, output opcode, output gram, output word_index, input ready);
   modport sink   (input valid, input opcode, input gram, input word_index, output ready);
endinterface

interface mqcb_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] absent_gram;
   logic [15:0] absent_index;
   logic        last;
   modport source (output valid, output absent_gram, output absent_index, output last,
                   input ready);
   modport sink   (input valid, input absent_gram, input absent_index, input last,
                   output ready);
endinterface

FILE: hw/rtl/mqcb_ctrl.sv
// Sequencer for clear, insert and scan operations.
// Depends on mqcb_pkg.
`timescale 1ns / 1ps

module mqcb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_opcode,
   output logic              req_ready,
   input  mqcb_pkg::sts_type sts,
   output mqcb_pkg::cmd_type cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_EXT   = 4'd2;
   localparam logic [3:0] S_IRD   = 4'd3;
   localparam logic [3:0] S_IWR   = 4'd4;
   localparam logic [3:0] S_SRD   = 4'd5;
   localparam logic [3:0] S_SLD   = 4'd6;
   localparam logic [3:0] S_STEST = 4'd7;
   localparam logic [3:0] S_DEP   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;   // clearing pass after reset
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  mqcb_pkg::OP_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     state_in        = S_CLEAR;
                  end
                  mqcb_pkg::OP_INSERT: begin
                     cmd.latch_req = 1'b1;
                     cmd.bit_start = 1'b1;
                     state_in      = S_EXT;
                  end
                  mqcb_pkg::OP_SCAN: begin
                     cmd.latch_req = 1'b1;
                     state_in      = S_SRD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_EXT: begin
            cmd.bit_step = 1'b1;
            if (sts.bit_last) state_in = S_IRD;
         end
         S_IRD: begin
            cmd.rd_ins = 1'b1;
            state_in   = S_IWR;
         end
         S_IWR: begin
            cmd.wr_ins = 1'b1;
            state_in   = S_IDLE;
         end
         S_SRD: begin
            if (sts.widx_ok) begin
               cmd.rd_scan = 1'b1;
               state_in    = S_SLD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SLD: begin
            cmd.scan_load = 1'b1;
            state_in      = S_STEST;
         end
         S_STEST: begin
            priority if (sts.cur_zero) begin
               cmd.take_bit  = 1'b1;
               cmd.bit_start = 1'b1;
               cmd.bit_mode  = 1'b1;
               state_in      = S_DEP;
            end else if (sts.scan_end) begin
               state_in = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_DEP: begin
            cmd.bit_step = 1'b1;
            if (sts.bit_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.scan_next = 1'b1;
                  state_in      = S_STEST;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/mqcb_dp.sv
// Datapath: bitmap memory, mask register, byte-serial extract/deposit unit, scan and
// response registers. Depends on mqcb_pkg.
`timescale 1ns / 1ps

module mqcb_dp #(
   parameter int INDEX_BITS = mqcb_pkg::INDEX_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  mqcb_pkg::cmd_type cmd,
   output mqcb_pkg::sts_type sts,
   input  logic              csr_wr_en,
   input  logic [63:0]       csr_wr_data,
   input  logic [63:0]       req_gram,
   input  logic [9:0]        req_word_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [63:0]       rsp_absent_gram,
   output logic [15:0]       rsp_absent_index,
   output logic              rsp_last
);

   localparam int WB         = INDEX_BITS - 6;
   localparam int WORD_COUNT = 1 << WB;

   logic [63:0] mem [WORD_COUNT];

   logic [63:0] mask_ff;
   logic [63:0] gram_ff;
   logic [9:0]  widx_ff;
   logic [WB-1:0] clr_addr_ff;
   logic [63:0] rd_data_ff;

   logic        mode_ff;
   logic [63:0] acc_ff, acc_in;
   logic [6:0]  pos_ff, pos_in;
   logic [2:0]  byte_ff;

   logic [63:0] pending_ff;
   logic [5:0]  bit_ff;

   logic        out_valid_ff;
   logic [63:0] out_gram_ff;
   logic [15:0] out_index_ff;
   logic        out_last_ff;

   logic [WB-1:0]         widx_addr;
   logic [INDEX_BITS-1:0] idx;
   logic [63:0]           idx64;
   logic [WB-1:0]         ins_addr;
   logic [5:0]            ins_bit;

   assign widx_addr = WB'(widx_ff);
   assign idx       = {widx_addr, bit_ff};
   assign idx64     = 64'(idx);
   assign ins_addr  = acc_ff[INDEX_BITS-1:6];
   assign ins_bit   = acc_ff[5:0];

   // one mask byte per step; ones counted within the byte
   always_comb begin
      logic [3:0] cnt;
      logic [6:0] p;
      logic [5:0] q;
      acc_in = acc_ff;
      cnt    = '0;
      for (int k = 0; k < 8; k++) begin
         q = {byte_ff, 3'(k)};
         p = pos_ff + 7'(cnt);
         if (mask_ff[q]) begin
            if (mode_ff) acc_in[q] = idx64[p[5:0]];
            else         acc_in[p[5:0]] = gram_ff[q];
            cnt = cnt + 4'd1;
         end
      end
      pos_in = pos_ff + 7'(cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) mask_ff <= csr_wr_data;
         if (cmd.clear_start)     clr_addr_ff <= '0;
         else if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + WB'(1);
         if (cmd.out_load)        out_valid_ff <= 1'b1;
         else if (rsp_ready)      out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         gram_ff <= req_gram;
         widx_ff <= req_word_index;
      end
      if (cmd.bit_start) begin
         mode_ff <= cmd.bit_mode;
         acc_ff  <= '0;
         pos_ff  <= '0;
         byte_ff <= '0;
      end else if (cmd.bit_step) begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         byte_ff <= byte_ff + 3'd1;
      end
      if (cmd.scan_load) begin
         pending_ff <= ~rd_data_ff;
         bit_ff     <= '0;
      end else begin
         if (cmd.take_bit)  pending_ff[bit_ff] <= 1'b0;
         if (cmd.scan_next) bit_ff <= bit_ff + 6'd1;
      end
      if (cmd.out_load) begin
         out_gram_ff  <= acc_ff;
         out_index_ff <= idx64[15:0];
         out_last_ff  <= (pending_ff == '0);
      end
   end

   // bitmap memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_step)  mem[clr_addr_ff] <= '0;
      else if (cmd.wr_ins) mem[ins_addr] <= rd_data_ff | (64'd1 << ins_bit);
      if (cmd.rd_ins)       rd_data_ff <= mem[ins_addr];
      else if (cmd.rd_scan) rd_data_ff <= mem[widx_addr];
   end

   assign sts.clear_last = (clr_addr_ff == WB'(WORD_COUNT - 1));
   assign sts.bit_last   = (byte_ff == 3'd7);
   assign sts.widx_ok    = (32'(widx_ff) < 32'(WORD_COUNT));
   assign sts.cur_zero   = pending_ff[bit_ff];
   assign sts.scan_end   = (bit_ff == 6'd63);
   assign sts.out_free   = !out_valid_ff || rsp_ready;
   assign sts.out_last   = (pending_ff == '0);

   assign rsp_valid        = out_valid_ff;
   assign rsp_absent_gram  = out_gram_ff;
   assign rsp_absent_index = out_index_ff;
   assign rsp_last         = out_last_ff;

   a_out_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_ready))
      else $error("response overwritten");
   a_take_zero : assert property (@(posedge clock) disable iff (reset)
      cmd.take_bit |-> pending_ff[bit_ff])
      else $error("took a set bit");
   a_mem_port : assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_step && cmd.wr_ins))
      else $error("two memory writes");

endmodule

FILE: hw/rtl/masked_qgram_complement_bitmap.sv
// Top level of the masked q-gram presence bitmap with complement scan.
// Depends on mqcb_pkg, mqcb_if, mqcb_ctrl and mqcb_dp.
`timescale 1ns / 1ps

// The block holds a 2^INDEX_BITS-bit presence bitmap in 2^(INDEX_BITS-6) words of
// 64 bits. Opcode 0 clears it, 1 sets the bit indexed by the gram bits that
// the mask register picks (packed lowest first, low INDEX_BITS kept), 2 scans one
// word and returns one item per clear bit, lowest first, with the index deposited
// back into the mask positions and last on the final item. Items are taken one at
// a time. Clear takes the item, then sweeps one word per cycle over all
// 2^(INDEX_BITS-6) words, 1024 at the default; the same sweep runs after reset
// before the first item is taken. Insert walks the mask through the extract unit
// one byte per cycle, then does a read and a write of the bitmap memory. Scan reads
// the word and tests it one bit per cycle; every clear bit pauses the test while it
// runs the byte-serial deposit unit and waits for the response register to be free.
// Opcode 3 and a word beyond the bitmap give no items.

module masked_qgram_complement_bitmap #(
   parameter int INDEX_BITS = mqcb_pkg::INDEX_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mqcb_req_if.sink    req_chan,
   mqcb_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);

   mqcb_pkg::cmd_type cmd;
   mqcb_pkg::sts_type sts;

   // controller owns request ready
   mqcb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath owns the response register
   mqcb_dp #(.INDEX_BITS(INDEX_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_gram         (req_chan.gram),
      .req_word_index   (req_chan.word_index),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_absent_gram  (rsp_chan.absent_gram),
      .rsp_absent_index (rsp_chan.absent_index),
      .rsp_last         (rsp_chan.last)
   );

endmodule
